FILE: design/hts_pkg.sv
// hts_pkg: shared constants for the height-field triangle sampler.
// No dependencies.
`default_nettype none

package hts_pkg;

  localparam int MapSideDefault      = 256;
  localparam int CoordFracBitsDefault = 8;

  // item opcodes
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // output field limits
  localparam int HeightMax = 32767;
  localparam int HeightMin = -32768;

endpackage

`default_nettype wire

FILE: design/heightfield_triangle_sampler_core.sv
// Height-field triangle sampler: four-bank sample store, query pipeline, output register.
// Depends on hts_pkg.
// A result word passes through stages 1, 2 and 3 and the output register.
// Throughput: one word per cycle unless stalled; each cell corner has its own bank.
// Reset: asynchronous, active low; clears the pipeline valid flags and map_ready.
// The sample store is not cleared; unwritten samples read as whatever the RAM holds.
`default_nettype none

module heightfield_triangle_sampler_core
  import hts_pkg::*;
#(
  parameter int MapSide       = MapSideDefault,
  parameter int CoordFracBits = CoordFracBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic               cfg_map_ready_i,
  // input words
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               op_i,
  input  wire logic [7:0]         sample_x_i,
  input  wire logic [7:0]         sample_z_i,
  input  wire logic signed [15:0] height_in_i,
  input  wire logic signed [17:0] query_x_i,
  input  wire logic signed [17:0] query_z_i,
  // result words
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [15:0] height_out_o,
  output      logic               outside_map_o
);

  // ---------------------------------------------------------------------------
  // Widths. Positions are held in half-LSB units (u2 = 2*x + MapSide*one) so an
  // odd side length keeps its half-sample offset exact.
  // ---------------------------------------------------------------------------
  localparam int F    = CoordFracBits;
  localparam int CW   = $clog2(MapSide);          // cell / sample index
  localparam int HW   = CW - 1;                   // index within one bank
  localparam int AW   = 2 * HW;                   // bank address
  localparam int UW0  = CW + F + 2;
  localparam int UW   = ((UW0 > 19) ? UW0 : 19) + 1;
  localparam int DW   = F + 2;                    // dx, dz (below two cells)
  localparam int PW   = F + 20;                   // one plane product
  localparam int NW   = F + 23;                   // plane numerator
  localparam int XW   = (CW > 8) ? CW : 8;
  localparam int One2 = 1 << (F + 1);

  localparam logic signed [UW-1:0] Offset = UW'(longint'(MapSide) << F);
  localparam logic signed [UW-1:0] Span2  = UW'(longint'(MapSide) << (F + 1));
  localparam logic signed [NW-1:0] SatHi  = NW'(HeightMax);
  localparam logic signed [NW-1:0] SatLo  = NW'(HeightMin);

  // ---------------------------------------------------------------------------
  // Handshake: each stage moves when it is empty or the next one moves.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, ov_q;
  logic en1, en2, en3, en_out;
  logic acc;

  assign en_out     = !ov_q || out_ready_i;
  assign en3        = !v3_q || en_out;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign acc        = in_valid_i && en1;

  // Config: always ready; user keeps the block idle when it is written, unchecked.
  logic map_ready_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_ready_q <= 1'b0;
    end else if (cfg_valid_i) begin
      map_ready_q <= cfg_map_ready_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Query front end: shift to the map corner, range check, cell index with
  // clamp to the last full cell, in-cell offsets and triangle choice.
  // ---------------------------------------------------------------------------
  logic signed [UW-1:0] u2, v2;
  logic                 in_map;
  logic [CW-1:0]        lx_raw, lz_raw, lx, lz;
  logic                 clamp_x, clamp_z;
  logic [DW-1:0]        dx, dz;
  logic [DW:0]          dsum;
  logic                 upper;

  assign u2 = UW'($signed({query_x_i, 1'b0})) + Offset;
  assign v2 = UW'($signed({query_z_i, 1'b0})) + Offset;

  assign in_map = !u2[UW-1] && !v2[UW-1] && (u2 < Span2) && (v2 < Span2);

  assign lx_raw  = u2[F+CW:F+1];
  assign lz_raw  = v2[F+CW:F+1];
  assign clamp_x = (lx_raw == CW'(MapSide - 1));
  assign clamp_z = (lz_raw == CW'(MapSide - 1));
  assign lx      = clamp_x ? CW'(MapSide - 2) : lx_raw;
  assign lz      = clamp_z ? CW'(MapSide - 2) : lz_raw;

  // clamping moves the cell back by one, so the offset gains a whole cell
  assign dx    = {clamp_x, u2[F:0]};
  assign dz    = {clamp_z, v2[F:0]};
  assign dsum  = {1'b0, dx} + {1'b0, dz};
  assign upper = dsum > (DW + 1)'(One2);

  // Bank {row parity, column parity} holds exactly one corner of any cell.
  // The odd column of the cell is lx or lx+1, both at half index lx>>1; the
  // even one sits one half index further on when lx is odd.
  logic [HW-1:0] xh_odd, xh_even, zh_odd, zh_even;
  assign xh_odd  = lx[CW-1:1];
  assign xh_even = lx[CW-1:1] + HW'(lx[0]);
  assign zh_odd  = lz[CW-1:1];
  assign zh_even = lz[CW-1:1] + HW'(lz[0]);

  // ---------------------------------------------------------------------------
  // Sample writes
  // ---------------------------------------------------------------------------
  logic [XW-1:0] sx_w, sz_w;
  logic          wr_ok;
  logic [CW-1:0] wcol, wrow;
  logic [AW-1:0] waddr;
  logic          is_write, is_query;

  assign is_write = (op_i == OpWrite);
  assign is_query = (op_i == OpQuery);
  assign sx_w     = XW'(sample_x_i);
  assign sz_w     = XW'(sample_z_i);
  assign wr_ok    = (32'(sx_w) < 32'(MapSide)) && (32'(sz_w) < 32'(MapSide));
  assign wcol     = sx_w[CW-1:0];
  assign wrow     = sz_w[CW-1:0];
  assign waddr    = {wrow[CW-1:1], wcol[CW-1:1]};

  // ---------------------------------------------------------------------------
  // Four sample banks, one read and one write port each, registered read.
  // A write and a read never share an edge, so a query always sees every
  // earlier write.
  // ---------------------------------------------------------------------------
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BankId = 2'(b);
    logic [15:0]        mem [2**AW];
    logic [AW-1:0]      raddr;
    logic               we, re;
    logic signed [15:0] rd_q;

    assign raddr = {(BankId[1] ? zh_odd : zh_even), (BankId[0] ? xh_odd : xh_even)};
    assign we    = acc && is_write && wr_ok && ({wrow[0], wcol[0]} == BankId);
    assign re    = acc && is_query;

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= height_in_i;
      end
      if (re) begin
        rd_q <= mem[raddr];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: read data arrives; keep the cell offsets and the force-zero flags.
  // ---------------------------------------------------------------------------
  logic          zero1_q, outs1_q, px1_q, pz1_q, up1_q;
  logic [DW-1:0] dx1_q, dz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      zero1_q <= is_write || !map_ready_q || !in_map;
      outs1_q <= is_query && (!map_ready_q || !in_map);
      px1_q   <= lx[0];
      pz1_q   <= lz[0];
      up1_q   <= upper;
      dx1_q   <= dx;
      dz1_q   <= dz;
    end
  end

  // corners by parity of the cell origin
  logic signed [15:0] h00, h10, h01, h11;
  assign h00 = pz1_q ? (px1_q ? g_bank[3].rd_q : g_bank[2].rd_q)
                     : (px1_q ? g_bank[1].rd_q : g_bank[0].rd_q);
  assign h10 = pz1_q ? (px1_q ? g_bank[2].rd_q : g_bank[3].rd_q)
                     : (px1_q ? g_bank[0].rd_q : g_bank[1].rd_q);
  assign h01 = pz1_q ? (px1_q ? g_bank[1].rd_q : g_bank[0].rd_q)
                     : (px1_q ? g_bank[3].rd_q : g_bank[2].rd_q);
  assign h11 = pz1_q ? (px1_q ? g_bank[0].rd_q : g_bank[1].rd_q)
                     : (px1_q ? g_bank[2].rd_q : g_bank[3].rd_q);

  logic signed [17:0] base_d;
  logic signed [16:0] ga_d, gb_d;

  always_comb begin
    if (up1_q) begin
      base_d = 18'(h01) + 18'(h10) - 18'(h11);
      ga_d   = 17'(h11) - 17'(h01);
      gb_d   = 17'(h11) - 17'(h10);
    end else begin
      base_d = 18'(h00);
      ga_d   = 17'(h10) - 17'(h00);
      gb_d   = 17'(h01) - 17'(h00);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: plane base and gradients.
  // ---------------------------------------------------------------------------
  logic               zero2_q, outs2_q;
  logic signed [17:0] base2_q;
  logic signed [16:0] ga2_q, gb2_q;
  logic [DW-1:0]      dx2_q, dz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      zero2_q <= zero1_q;
      outs2_q <= outs1_q;
      base2_q <= base_d;
      ga2_q   <= ga_d;
      gb2_q   <= gb_d;
      dx2_q   <= dx1_q;
      dz2_q   <= dz1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: the two gradient products and the scaled base.
  // ---------------------------------------------------------------------------
  logic               zero3_q, outs3_q;
  logic signed [NW-1:0] pbase3_q;
  logic signed [PW-1:0] pa3_q, pb3_q;
  logic signed [PW-1:0] pa_d, pb_d;

  assign pa_d = PW'(ga2_q) * PW'($signed({1'b0, dx2_q}));
  assign pb_d = PW'(gb2_q) * PW'($signed({1'b0, dz2_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      zero3_q  <= zero2_q;
      outs3_q  <= outs2_q;
      pbase3_q <= NW'(base2_q) <<< (F + 1);
      pa3_q    <= pa_d;
      pb3_q    <= pb_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sum, divide by one cell (truncating toward zero), saturate.
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0] num, num_adj, quo;
  logic signed [15:0]   hsat;

  assign num     = pbase3_q + NW'(pa3_q) + NW'(pb3_q);
  assign num_adj = num[NW-1] ? (num + NW'(One2 - 1)) : num;
  assign quo     = num_adj >>> (F + 1);

  always_comb begin
    if (quo > SatHi) begin
      hsat = 16'(HeightMax);
    end else if (quo < SatLo) begin
      hsat = 16'(HeightMin);
    end else begin
      hsat = quo[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [15:0] hout_q;
  logic               outs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_out) begin
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && v3_q) begin
      hout_q <= zero3_q ? 16'sd0 : hsat;
      outs_q <= outs3_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign height_out_o  = hout_q;
  assign outside_map_o = outs_q;

endmodule

`default_nettype wire

FILE: design/hts_checker.sv
// hts_checker: port-level assertions for the height-field triangle sampler, and its bind.
// Depends on heightfield_triangle_sampler_core.
`default_nettype none

module hts_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [15:0] height_out_o,
  input wire logic               outside_map_o
);

  // a flagged word always carries a zero height
  a_outside_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outside_map_o) |-> (height_out_o == 16'sd0))
    else $error("outside_map word with non-zero height");

  // with the output register empty the whole pipe drains, so input is open
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // a stalled result word holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(height_out_o) && $stable(outside_map_o)))
    else $error("result word changed while stalled");

  // the configuration port never stalls
  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind heightfield_triangle_sampler_core hts_checker u_hts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .height_out_o (height_out_o),
  .outside_map_o(outside_map_o)
);

`default_nettype wire
